// ----- design/sq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the stack/queue engine.
// No dependencies; every other file of the block uses this package.
package sq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Command codes carried by the cmd field
    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_PRINT = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_POP   = 3'd3,
        CMD_SWAP  = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_PEEK_EMPTY = 3'd1,
        STAT_POP_EMPTY  = 3'd2,
        STAT_SWAP_SHORT = 3'd3,
        STAT_PUSH_FULL  = 3'd4
    } status_t;

    // Source selection for one cell of the chain
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_PREV = 2'd1,
        SEL_NEXT = 2'd2,
        SEL_LOAD = 2'd3
    } cell_sel_t;

    // Whole-chain operation for one cycle
    typedef enum logic [2:0] {
        CHAIN_HOLD      = 3'd0,
        CHAIN_PUSH_TOP  = 3'd1,
        CHAIN_PUSH_BACK = 3'd2,
        CHAIN_POP       = 3'd3,
        CHAIN_SWAP      = 3'd4,
        CHAIN_ROTATE    = 3'd5
    } chain_kind_t;

    typedef struct packed {
        chain_kind_t               kind;
        logic signed [DATA_W-1:0]  value;
    } chain_op_t;

    // Control state, one-hot
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PRINT = 2'b10
    } state_t;

endpackage

// ----- design/sq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on sq_pkg for the status type.
interface sq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface sq_res_if;
    logic               valid;
    logic               ready;
    sq_pkg::status_t    status;
    logic               has_value;
    logic signed [31:0] data_value;
    logic               last;

    modport source (output valid, output status, output has_value,
                    output data_value, output last, input ready);
    modport sink   (input valid, input status, input has_value,
                    input data_value, input last, output ready);
endinterface

// ----- design/sq_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the chain: holds a single element and takes its
// next value from itself, either neighbour or the shared load bus. Uses sq_pkg.
module sq_cell (
    input  logic                              clk,
    input  sq_pkg::cell_sel_t                 sel,
    input  logic signed [sq_pkg::DATA_W-1:0]  prev_data,
    input  logic signed [sq_pkg::DATA_W-1:0]  next_data,
    input  logic signed [sq_pkg::DATA_W-1:0]  load_data,
    output logic signed [sq_pkg::DATA_W-1:0]  data
);
    import sq_pkg::*;

    logic signed [DATA_W-1:0] cell_reg;
    logic signed [DATA_W-1:0] cell_next;

    // Pick the source for this cycle
    always_comb
    begin
        unique case (sel)
            SEL_HOLD: cell_next = cell_reg;
            SEL_PREV: cell_next = prev_data;
            SEL_NEXT: cell_next = next_data;
            SEL_LOAD: cell_next = load_data;
            default:  cell_next = cell_reg;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign data = cell_reg;

endmodule

// ----- design/sq_chain.sv -----
`timescale 1ns / 1ps
// Row of DEPTH cells; cell 0 holds the top element, cell k the k-th below it.
// Decodes the chain operation into per-cell selects. Uses sq_pkg and sq_cell.
module sq_chain (
    input  logic                              clk,
    input  sq_pkg::chain_op_t                 op,
    input  logic [sq_pkg::CNT_W-1:0]          count,
    output logic signed [sq_pkg::DATA_W-1:0]  top_value
);
    import sq_pkg::*;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] load_data;

    // Rotation feeds the top back into the tail; otherwise load the pushed value
    assign load_data = (op.kind == CHAIN_ROTATE) ? cell_data[0] : op.value;
    assign top_value = cell_data[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_sel_t                sel;
        logic signed [DATA_W-1:0] prev_data;
        logic signed [DATA_W-1:0] next_data;

        // Tie the chain ends back to the cell itself
        assign prev_data = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i - 1];
        assign next_data = (i == DEPTH - 1) ? cell_data[i]
                                            : cell_data[(i == DEPTH - 1) ? i : i + 1];

        // Decode the operation for this position
        always_comb
        begin
            unique case (op.kind)
                CHAIN_PUSH_TOP:
                    sel = (i == 0) ? SEL_LOAD : SEL_PREV;
                CHAIN_PUSH_BACK:
                    sel = (count == CNT_W'(i)) ? SEL_LOAD : SEL_HOLD;
                CHAIN_POP:
                    sel = (i == DEPTH - 1) ? SEL_HOLD : SEL_NEXT;
                CHAIN_SWAP:
                    sel = (i == 0) ? SEL_NEXT : ((i == 1) ? SEL_PREV : SEL_HOLD);
                CHAIN_ROTATE:
                    sel = (count == CNT_W'(i + 1)) ? SEL_LOAD
                        : ((i == DEPTH - 1) ? SEL_HOLD : SEL_NEXT);
                default:
                    sel = SEL_HOLD;
            endcase
        end

        sq_cell u_cell (
            .clk       (clk),
            .sel       (sel),
            .prev_data (prev_data),
            .next_data (next_data),
            .load_data (load_data),
            .data      (cell_data[i])
        );
    end

endmodule

// ----- design/stack_queue_engine_top.sv -----
`timescale 1ns / 1ps
// Stack/queue engine top level: command decode, count, print sequencer and
// result register. Uses sq_pkg, the sq_if interfaces and sq_chain.
//
// Usage:
//   cmd_in  : valid/ready command channel (cmd, push_value).
//   res_out : valid/ready result channel (status, has_value, data_value, last).
//   cfg_wr_en/cfg_wr_data set queue_mode (0 stack, 1 queue); write while idle.
// Elements sit in a row of cells with the top in cell 0. Push, pop, peek and
// swap complete in the accepting cycle; their single result is valid the
// next cycle, and a new command can be taken every cycle while results drain.
// Print all on a non-empty store enters the print state and then emits one
// element per cycle while res_out is not stalled, top to bottom, by rotating
// the occupied cells once round; it accepts no command until the last element is issued.
// Commands 5 to 7 are dropped with no result.
// The result register is refilled only once the receiver takes its content,
// so a stall on res_out holds both the result and cmd_in.ready low.
// Reset empties the store, clears queue_mode and drops any pending result;
// cell contents are not cleared and are never read before being written.
module stack_queue_engine_top (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_wr_en,
    input  logic  cfg_wr_data,
    sq_cmd_if.sink    cmd_in,
    sq_res_if.source  res_out
);
    import sq_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         left_reg, left_next;
    logic                     mode_reg;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic                     has_reg, has_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     last_reg, last_next;
    chain_op_t                op;
    logic signed [DATA_W-1:0] top_value;
    logic                     out_free;
    logic                     accept;

    // Result slot frees when empty or being taken
    assign out_free     = !out_valid_reg || res_out.ready;
    assign cmd_in.ready = (state_reg == ST_IDLE) && out_free;
    assign accept       = cmd_in.valid && cmd_in.ready;

    // Decode commands and sequence print all
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !res_out.ready;
        status_next    = status_reg;
        has_next       = has_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        op.kind        = CHAIN_HOLD;
        op.value       = cmd_in.push_value;

        if (accept)
        begin
            status_next = STAT_OK;
            has_next    = 1'b0;
            data_next   = '0;
            last_next   = 1'b1;
            unique case (cmd_in.cmd)
                CMD_PUSH:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == CNT_W'(DEPTH))
                        status_next = STAT_PUSH_FULL;
                    else
                    begin
                        op.kind    = mode_reg ? CHAIN_PUSH_BACK : CHAIN_PUSH_TOP;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PRINT:
                begin
                    if (count_reg == '0)
                        out_valid_next = 1'b1;
                    else
                    begin
                        state_next = ST_PRINT;
                        left_next  = count_reg;
                    end
                end
                CMD_PEEK:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                        status_next = STAT_PEEK_EMPTY;
                    else
                    begin
                        has_next  = 1'b1;
                        data_next = top_value;
                    end
                end
                CMD_POP:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                        status_next = STAT_POP_EMPTY;
                    else
                    begin
                        op.kind    = CHAIN_POP;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_SWAP:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg < CNT_W'(2))
                        status_next = STAT_SWAP_SHORT;
                    else
                        op.kind = CHAIN_SWAP;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !res_out.ready;
                end
            endcase
        end
        else if (state_reg == ST_PRINT && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            has_next       = 1'b1;
            data_next      = top_value;
            last_next      = (left_reg == CNT_W'(1));
            op.kind        = CHAIN_ROTATE;
            left_next      = left_reg - 1'b1;
            if (left_reg == CNT_W'(1))
                state_next = ST_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        has_reg    <= has_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    sq_chain u_chain (
        .clk       (clk),
        .op        (op),
        .count     (count_reg),
        .top_value (top_value)
    );

    assign res_out.valid      = out_valid_reg;
    assign res_out.status     = status_reg;
    assign res_out.has_value  = has_reg;
    assign res_out.data_value = data_reg;
    assign res_out.last       = last_reg;

    // Count never exceeds the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // Printing walks a non-empty range within the current count
    a_print_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRINT |-> (left_reg != '0) && (left_reg <= count_reg))
        else $error("print counter out of range");

    // Count stays fixed while printing
    a_print_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRINT |=> $stable(count_reg))
        else $error("count changed during print");

    // The final print element returns to idle
    a_print_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRINT && out_free && left_reg == CNT_W'(1))
        |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("print did not finish with last");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stack_queue_engine_top: directed and random command traffic,
// checked against an in-bench shadow of the store. Depends on sq_pkg, sq_if and the design.
module testbench;
    import sq_pkg::*;

    localparam int          IDX_W       = $clog2(DEPTH);
    localparam int          IDLE_PCT    = 11;
    localparam int          SETTLE      = 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic        MODE_STACK  = 1'b0;
    localparam logic        MODE_QUEUE  = 1'b1;
    localparam logic [2:0]  CMD_UNUSED_A = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_B = 3'd6;
    localparam logic [2:0]  CMD_UNUSED_C = 3'd7;

    typedef struct {
        status_t            status;
        logic               has_value;
        logic signed [31:0] data_value;
        logic               last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    sq_cmd_if cmd_bus ();
    sq_res_if res_bus ();

    stack_queue_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_in      (cmd_bus),
        .res_out     (res_bus)
    );

    // Shadow of the store: circular buffer with the top at shadow_head
    logic signed [31:0] shadow_cells [DEPTH];
    logic [IDX_W-1:0]   shadow_head;
    logic [IDX_W:0]     shadow_count;
    logic               shadow_queue_mode;

    result_t pending_results [$];
    int      fail_count;
    int      rx_hold_cycles;
    bit      tx_idle_en;
    bit      rx_idle_en;
    int      cycle_count;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_expected(input status_t st, input logic hv,
                                input logic signed [31:0] dv, input logic lst);
        result_t r;
        r.status     = st;
        r.has_value  = hv;
        r.data_value = dv;
        r.last       = lst;
        pending_results.push_back(r);
    endtask

    // Advance the shadow store by one command and queue the results it gives
    task automatic predict_command(input logic [2:0] code, input logic signed [31:0] value);
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic signed [31:0] t;
        int                 i;
        case (code)
            CMD_PUSH:
                if (shadow_count >= DEPTH)
                    add_expected(STAT_PUSH_FULL, 1'b0, '0, 1'b1);
                else
                begin
                    if (shadow_queue_mode)
                    begin
                        a = shadow_head + shadow_count[IDX_W-1:0];
                        shadow_cells[a] = value;
                    end
                    else
                    begin
                        shadow_head = shadow_head - 1'b1;
                        shadow_cells[shadow_head] = value;
                    end
                    shadow_count++;
                    add_expected(STAT_OK, 1'b0, '0, 1'b1);
                end
            CMD_PRINT:
                if (shadow_count == 0)
                    add_expected(STAT_OK, 1'b0, '0, 1'b1);
                else
                    for (i = 0; i < shadow_count; i++)
                    begin
                        a = shadow_head + IDX_W'(i);
                        add_expected(STAT_OK, 1'b1, shadow_cells[a], (i + 1) == shadow_count);
                    end
            CMD_PEEK:
                if (shadow_count == 0)
                    add_expected(STAT_PEEK_EMPTY, 1'b0, '0, 1'b1);
                else
                    add_expected(STAT_OK, 1'b1, shadow_cells[shadow_head], 1'b1);
            CMD_POP:
                if (shadow_count == 0)
                    add_expected(STAT_POP_EMPTY, 1'b0, '0, 1'b1);
                else
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count--;
                    add_expected(STAT_OK, 1'b0, '0, 1'b1);
                end
            CMD_SWAP:
                if (shadow_count < 2)
                    add_expected(STAT_SWAP_SHORT, 1'b0, '0, 1'b1);
                else
                begin
                    a = shadow_head;
                    b = shadow_head + 1'b1;
                    t = shadow_cells[a];
                    shadow_cells[a] = shadow_cells[b];
                    shadow_cells[b] = t;
                    add_expected(STAT_OK, 1'b0, '0, 1'b1);
                end
            default:
                ;
        endcase
    endtask

    // Predict on every accepted command; inputs are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
            predict_command(cmd_bus.cmd, cmd_bus.push_value);
    end

    // Check every accepted result against the oldest expectation
    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d data_value %0d",
                       res_bus.status, res_bus.data_value);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    fail_count++;
                end
                if (res_bus.has_value !== want.has_value)
                begin
                    $error("has_value: expected %0d, got %0d",
                           want.has_value, res_bus.has_value);
                    fail_count++;
                end
                if (res_bus.data_value !== want.data_value)
                begin
                    $error("data_value: expected %0d, got %0d",
                           want.data_value, res_bus.data_value);
                    fail_count++;
                end
                if (res_bus.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res_bus.last);
                    fail_count++;
                end
            end
        end
    end

    // Result receiver: long hold-off on request, otherwise random stalls when enabled
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            res_bus.ready <= 1'b0;
            rx_hold_cycles--;
        end
        else
            res_bus.ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Offer one command and hold it until the transaction completes
    task automatic send_command(input logic [2:0] code, input logic signed [31:0] value);
        bit fire;
        if (tx_idle_en)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                cmd_bus.valid <= 1'b0;
                @(posedge clk);
            end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.cmd        <= code;
        cmd_bus.push_value <= value;
        do
        begin
            @(negedge clk);
            fire = cmd_bus.ready;
            @(posedge clk);
        end
        while (!fire);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; only called with the engine idle
    task automatic write_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_queue_mode = mode;
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_store();
        write_mode(MODE_STACK);
        send_command(CMD_PRINT, 0);
        send_command(CMD_PEEK, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_SWAP, 0);
        send_command(CMD_UNUSED_A, -32'sd1);
        drain_results();
    endtask

    task automatic test_stack_ops();
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_PUSH, 32'sh7fff_ffff);
        send_command(CMD_PUSH, 32'sd0);
        send_command(CMD_PUSH, -32'sd1);
        send_command(CMD_PEEK, 32'sh7fff_ffff);
        send_command(CMD_SWAP, 0);
        send_command(CMD_PRINT, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_SWAP, 0);
        send_command(CMD_UNUSED_B, 32'sh5555_aaaa);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        // one element left: swap is short
        send_command(CMD_SWAP, 0);
        send_command(CMD_PEEK, 0);
        send_command(CMD_UNUSED_C, 32'sh2aaa_5555);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        drain_results();
    endtask

    // Fill in queue mode behind a stalled receiver, then wrap the buffer round
    task automatic test_queue_fill();
        int k;
        write_mode(MODE_QUEUE);
        @(negedge clk);
        rx_hold_cycles = 300;
        @(posedge clk);
        for (k = 0; k < DEPTH; k++)
            send_command(CMD_PUSH, random_value());
        send_command(CMD_PUSH, random_value());
        send_command(CMD_PEEK, 0);
        send_command(CMD_SWAP, 0);
        send_command(CMD_PRINT, 0);
        for (k = 0; k < DEPTH / 2; k++)
            send_command(CMD_POP, 0);
        for (k = 0; k < DEPTH / 4; k++)
            send_command(CMD_PUSH, random_value());
        send_command(CMD_PRINT, 0);
        drain_results();
    endtask

    // Fill in stack mode, push once more, print and swap, then empty it and pop once more
    task automatic test_stack_fill();
        int k;
        write_mode(MODE_STACK);
        for (k = 0; k < DEPTH; k++)
            send_command(CMD_PUSH, random_value());
        send_command(CMD_PUSH, random_value());
        send_command(CMD_PRINT, 0);
        send_command(CMD_SWAP, 0);
        for (k = 0; k <= DEPTH; k++)
            send_command(CMD_POP, 0);
        drain_results();
    endtask

    // Random command mix; pause halfway until every result is in
    task automatic test_random_traffic(input logic mode, input int n_items,
                                       input int push_pct, input bit idle_on);
        int         sent;
        int         pick;
        logic [2:0] code;
        write_mode(mode);
        tx_idle_en = idle_on;
        rx_idle_en = idle_on;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < push_pct)
                code = CMD_PUSH;
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    code = CMD_POP;
                else if (pick < 11)
                    code = CMD_PEEK;
                else if (pick < 14)
                    code = CMD_SWAP;
                else if (pick < 18)
                    code = CMD_PRINT;
                else
                    code = 3'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C));
            end
            send_command(code, random_value());
            if (code <= CMD_SWAP)
                sent++;
            if (sent == n_items / 2 && code <= CMD_SWAP)
                drain_results();
        end
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.cmd        = CMD_PUSH;
        cmd_bus.push_value = '0;
        res_bus.ready      = 1'b0;
        shadow_head        = '0;
        shadow_count       = '0;
        shadow_queue_mode  = MODE_STACK;
        fail_count         = 0;
        rx_hold_cycles     = 0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_stack_ops();
        test_queue_fill();
        test_stack_fill();
        test_random_traffic(MODE_STACK, 8, 45, 1'b1);
        test_random_traffic(MODE_QUEUE, 8, 45, 1'b1);
        test_random_traffic(MODE_QUEUE, 24, 70, 1'b0);
        test_random_traffic(MODE_STACK, 8, 35, 1'b1);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- stack_queue_engine_top.f -----
design/sq_pkg.sv
design/sq_if.sv
design/sq_cell.sv
design/sq_chain.sv
design/stack_queue_engine_top.sv
tb/sv/testbench.sv
